[sv/sacl_pkg.sv]
// ---------------------------------------------------------------------------
// sacl_pkg
// Shared types and constants of the set-associative cache lookup core.
// ---------------------------------------------------------------------------
package sacl_pkg;

  localparam int MAX_SETS   = 256;
  localparam int MAX_WAYS   = 8;
  localparam int ADDR_BITS  = 48;
  localparam int OFFSET_W   = 6;                      // 64-byte blocks
  localparam int BLOCK_W    = ADDR_BITS - OFFSET_W;   // block number bits
  localparam int TAG_W      = BLOCK_W;
  localparam int SET_W      = $clog2(MAX_SETS);
  localparam int SETS_W     = 9;                      // set-count register
  localparam int WAYS_W     = 4;                      // way-count register
  localparam int WAY_W      = 3;
  localparam int RANK_W     = 3;
  localparam int CNT_W      = 48;
  localparam int DIV_STEP   = 2;                      // quotient bits per cycle
  localparam int DIV_ITER   = BLOCK_W / DIV_STEP;
  localparam int DIV_CNT_W  = $clog2(DIV_ITER + 1);
  localparam int OUT_W      = 200;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SETS = 2'd0,
    CFG_WAYS = 2'd1,
    CFG_REPL = 2'd2,
    CFG_WB   = 2'd3
  } cfg_idx_e;

  typedef logic [MAX_WAYS-1:0][RANK_W-1:0] rank_row_t;

  // one memory row holds a whole set
  typedef struct packed {
    logic [MAX_WAYS-1:0]            valid;
    logic [MAX_WAYS-1:0]            dirty;
    logic [MAX_WAYS-1:0][TAG_W-1:0] tag;
    rank_row_t                      rrank;
    rank_row_t                      frank;
  } row_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic mem_rd;
    logic look;
    logic upd;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic div_done;
    logic out_free;
  } ctrl_sts_t;

endpackage

[sv/sacl_div.sv]
// ---------------------------------------------------------------------------
// sacl_div
// Restoring divider: block number by set count, two quotient bits a cycle.
// ---------------------------------------------------------------------------
module sacl_div import sacl_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [BLOCK_W-1:0] dividend_i,
  input  logic [SETS_W-1:0]  divisor_i,
  output logic               done_o,
  output logic [BLOCK_W-1:0] quot_o,
  output logic [SETS_W-1:0]  rem_o
);

  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [BLOCK_W-1:0]   quot_q, quot_d;
  logic [SETS_W-1:0]    rem_q, rem_d;
  logic [SETS_W-1:0]    dvs_q;

  // two dependent compare-subtract steps
  always_comb begin
    logic [SETS_W:0] part;
    quot_d = quot_q;
    rem_d  = rem_q;
    for (int s = 0; s < DIV_STEP; s++) begin
      part   = {rem_d, quot_d[BLOCK_W-1]};
      quot_d = {quot_d[BLOCK_W-2:0], 1'b0};
      if (part >= {1'b0, dvs_q}) begin
        part      = part - {1'b0, dvs_q};
        quot_d[0] = 1'b1;
      end
      rem_d = part[SETS_W-1:0];
    end
    cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= DIV_CNT_W'(DIV_ITER);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      dvs_q  <= divisor_i;
    end else if (cnt_q != '0) begin
      quot_q <= quot_d;
      rem_q  <= rem_d;
    end
  end

  assign done_o = (cnt_q == '0);
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

[sv/sacl_ctrl.sv]
// ---------------------------------------------------------------------------
// sacl_ctrl
// Sequencer: accept, divide, read set row, look up, update and emit.
// ---------------------------------------------------------------------------
module sacl_ctrl import sacl_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  ctrl_sts_t sts_i,
  output ctrl_cmd_t cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV  = 5'b00010,
    S_READ = 5'b00100,
    S_LOOK = 5'b01000,
    S_UPD  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d       = state_q;
    in_ready_o    = 1'b0;
    cmd_o         = '0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i) state_d = S_DIV;
      end
      S_DIV: begin
        if (sts_i.div_done) state_d = S_READ;
      end
      S_READ: begin
        cmd_o.mem_rd = 1'b1;
        state_d      = S_LOOK;
      end
      S_LOOK: begin
        cmd_o.look = 1'b1;
        state_d    = S_UPD;
      end
      S_UPD: begin
        if (sts_i.out_free) begin
          cmd_o.upd = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[sv/sacl_dp.sv]
// ---------------------------------------------------------------------------
// sacl_dp
// Datapath: set/tag split, set-row memory, way match, victim pick, rank
// update, saturating counters and the output register.
// ---------------------------------------------------------------------------
module sacl_dp import sacl_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ctrl_cmd_t             cmd_i,
  output ctrl_sts_t             sts_o,
  input  logic                  in_cmd_i,
  input  logic [ADDR_BITS-1:0]  in_addr_i,
  input  logic [SETS_W-1:0]     cfg_sets_i,
  input  logic [WAYS_W-1:0]     cfg_ways_i,
  input  logic                  cfg_repl_i,
  input  logic                  cfg_wb_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [OUT_W-1:0]      out_data_o
);

  // move way w to rank 0, age the newer valid lines by one
  function automatic rank_row_t promote(input rank_row_t rank,
                                        input logic [MAX_WAYS-1:0] vld,
                                        input logic [WAY_W-1:0] w);
    rank_row_t       res;
    logic [RANK_W:0] old;
    res = rank;
    old = vld[w] ? {1'b0, rank[w]} : (RANK_W+1)'(MAX_WAYS);
    for (int v = 0; v < MAX_WAYS; v++) begin
      if (WAY_W'(v) != w && vld[v] && {1'b0, rank[v]} < old) res[v] = rank[v] + 1'b1;
    end
    res[w] = '0;
    return res;
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  // per-access registers, loaded on accept
  logic                is_wr_q, repl_q, wb_q;
  logic [SETS_W-1:0]   sets_c;
  logic [WAYS_W-1:0]   ways_q, ways_c;

  always_comb begin
    sets_c = cfg_sets_i;
    if (cfg_sets_i == '0) sets_c = SETS_W'(1);
    else if (cfg_sets_i > SETS_W'(MAX_SETS)) sets_c = SETS_W'(MAX_SETS);
    ways_c = cfg_ways_i;
    if (cfg_ways_i == '0) ways_c = WAYS_W'(1);
    else if (cfg_ways_i > WAYS_W'(MAX_WAYS)) ways_c = WAYS_W'(MAX_WAYS);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      is_wr_q <= in_cmd_i;
      repl_q  <= cfg_repl_i;
      wb_q    <= cfg_wb_i;
      ways_q  <= ways_c;
    end
  end

  // tag = block / sets, set = block % sets
  logic [BLOCK_W-1:0] tag;
  logic [SETS_W-1:0]  rem;
  logic [SET_W-1:0]   set;

  sacl_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.accept),
    .dividend_i (in_addr_i[ADDR_BITS-1:OFFSET_W]),
    .divisor_i  (sets_c),
    .done_o     (sts_o.div_done),
    .quot_o     (tag),
    .rem_o      (rem)
  );
  assign set = rem[SET_W-1:0];

  // set-row memory; a row never written reads as all lines invalid
  row_t                mem_q [MAX_SETS];
  row_t                rd_q, wr_row;
  logic [MAX_SETS-1:0] row_ok_q;
  logic                rd_ok_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.upd) mem_q[set] <= wr_row;
    if (cmd_i.mem_rd) rd_q <= mem_q[set];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_ok_q <= '0;
      rd_ok_q  <= 1'b0;
    end else begin
      if (cmd_i.upd) row_ok_q[set] <= 1'b1;
      if (cmd_i.mem_rd) rd_ok_q <= row_ok_q[set];
    end
  end

  logic [MAX_WAYS-1:0] valid_e, dirty_e, mask;
  assign valid_e = rd_ok_q ? rd_q.valid : '0;
  assign dirty_e = rd_ok_q ? rd_q.dirty : '0;

  // way match and victim choice
  logic             hit_c, inv_c;
  logic [WAY_W-1:0] hit_way_c, inv_way_c, old_way_c;
  logic             hit_q;
  logic [WAY_W-1:0] hit_way_q, vict_q;

  always_comb begin
    rank_row_t       rk;
    logic [RANK_W-1:0] oldest;
    hit_c     = 1'b0;
    inv_c     = 1'b0;
    hit_way_c = '0;
    inv_way_c = '0;
    old_way_c = '0;
    rk        = repl_q ? rd_q.frank : rd_q.rrank;
    oldest    = rk[0];
    for (int w = 0; w < MAX_WAYS; w++) mask[w] = (WAYS_W'(w) < ways_q);
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (mask[w] && valid_e[w] && rd_q.tag[w] == tag) begin
        hit_c     = 1'b1;
        hit_way_c = WAY_W'(w);
      end
      if (mask[w] && !valid_e[w]) begin
        inv_c     = 1'b1;
        inv_way_c = WAY_W'(w);
      end
    end
    for (int w = 1; w < MAX_WAYS; w++) begin
      if (mask[w] && rk[w] > oldest) begin
        oldest    = rk[w];
        old_way_c = WAY_W'(w);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.look) begin
      hit_q     <= hit_c;
      hit_way_q <= hit_way_c;
      vict_q    <= inv_c ? inv_way_c : old_way_c;
    end
  end

  // state update and result
  logic             filled, mrd, mwr;
  logic [WAY_W-1:0] way_out;
  logic [CNT_W-1:0] hits_q, hits_d, miss_q, miss_d, rds_q, rds_d, wrs_q, wrs_d;

  always_comb begin
    wr_row       = rd_q;
    wr_row.valid = valid_e;
    wr_row.dirty = dirty_e;
    filled       = 1'b0;
    mrd          = 1'b0;
    mwr          = 1'b0;
    way_out      = '0;
    if (hit_q) begin
      way_out = hit_way_q;
      if (!repl_q) wr_row.rrank = promote(rd_q.rrank, valid_e, hit_way_q);
      if (is_wr_q) begin
        if (wb_q) wr_row.dirty[hit_way_q] = 1'b1;
        else      mwr = 1'b1;
      end
    end else if (!is_wr_q || wb_q) begin
      mwr                   = valid_e[vict_q] & wb_q & dirty_e[vict_q];
      mrd                   = 1'b1;
      filled                = 1'b1;
      way_out               = vict_q;
      wr_row.rrank          = promote(rd_q.rrank, valid_e, vict_q);
      wr_row.frank          = promote(rd_q.frank, valid_e, vict_q);
      wr_row.valid[vict_q]  = 1'b1;
      wr_row.tag[vict_q]    = tag;
      wr_row.dirty[vict_q]  = is_wr_q;
    end else begin
      mwr = 1'b1;
    end
    hits_d = hit_q ? sat_inc(hits_q) : hits_q;
    miss_d = hit_q ? miss_q : sat_inc(miss_q);
    rds_d  = mrd ? sat_inc(rds_q) : rds_q;
    wrs_d  = mwr ? sat_inc(wrs_q) : wrs_q;
  end

  logic out_valid_q;
  logic [OUT_W-1:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hits_q      <= '0;
      miss_q      <= '0;
      rds_q       <= '0;
      wrs_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.upd) begin
        hits_q      <= hits_d;
        miss_q      <= miss_d;
        rds_q       <= rds_d;
        wrs_q       <= wrs_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.upd) begin
      out_data_q <= {1'b0, wrs_d, rds_d, miss_d, hits_d, mwr, mrd, filled, way_out, hit_q};
    end
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_data_q;

  // checks
  a_upd_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.upd |-> (!out_valid_q || out_ready_i)) else $error("result overwritten");
  a_rd_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mem_rd |-> sts_o.div_done) else $error("row read before divide done");
  a_upd_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.upd |=> out_valid_q) else $error("result not presented");
  a_hit_no_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_data_q[0] && out_data_q[4])) else $error("hit with fill");

endmodule

[sv/set_assoc_cache_lookup_core.sv]
// ---------------------------------------------------------------------------
// set_assoc_cache_lookup_core
// Tag/state model of a 64-byte-block set-associative cache, LRU or FIFO,
// write-back or write-through.
// ---------------------------------------------------------------------------
// One access is in flight at a time: an accepted beat must pass through the
// divider that splits the block number into tag and set index two quotient
// bits a cycle, followed by the set-row read, the lookup and the update that
// loads the result register, before the next beat can be taken. A finished
// result waits in that register while the next access proceeds; the update
// stalls only if the previous result is still untaken. Set state lives in
// one memory row per set; per-set valid flags clear at reset, so no clearing
// pass is needed. Configuration writes are taken every cycle and should be
// made only while the core is idle.
// ---------------------------------------------------------------------------
module set_assoc_cache_lookup_core import sacl_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // slave stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [ADDR_BITS-1:0]  s_axis_tdata,  // [47:0] address
  input  logic                  s_axis_tuser,  // [0] cmd (0 read, 1 write)
  // master stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_W-1:0]      m_axis_tdata,  // [0] hit, [3:1] way_used,
                                               // [4] line_filled, [5] memory_read,
                                               // [6] memory_write, [54:7] total_hits,
                                               // [102:55] total_misses,
                                               // [150:103] total_mem_reads,
                                               // [198:151] total_mem_writes, [199] 0
  // configuration writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [SETS_W-1:0] sets_q;
  logic [WAYS_W-1:0] ways_q;
  logic              repl_q, wb_q;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sets_q <= SETS_W'(MAX_SETS);
      ways_q <= WAYS_W'(MAX_WAYS);
      repl_q <= 1'b0;
      wb_q   <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_SETS: sets_q <= cfg_data_i[SETS_W-1:0];
        CFG_WAYS: ways_q <= cfg_data_i[WAYS_W-1:0];
        CFG_REPL: repl_q <= cfg_data_i[0];
        CFG_WB:   wb_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  sacl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sacl_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_cmd_i    (s_axis_tuser),
    .in_addr_i   (s_axis_tdata),
    .cfg_sets_i  (sets_q),
    .cfg_ways_i  (ways_q),
    .cfg_repl_i  (repl_q),
    .cfg_wb_i    (wb_q),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata)
  );

endmodule
